// ===== rtl/drrip_pkg.sv =====
package drrip_pkg;

    localparam int DEF_NUM_SETS       = 2048;
    localparam int DEF_NUM_WAYS       = 16;
    localparam int DEF_LEADER_COUNT   = 64;
    localparam int DEF_SIGNATURE_BITS = 5;
    localparam int DEF_SELECTOR_BITS  = 10;

    localparam logic [1:0] MAX_AGE        = 2'd3;
    localparam logic [1:0] AGE_RESET      = 2'd2;
    localparam logic [1:0] AGE_NEAR       = 2'd0;
    localparam logic [1:0] OUTCOME_RESET  = 2'd1;
    localparam logic [1:0] OUTCOME_MAX    = 2'd3;
    localparam logic [1:0] OUTCOME_STRONG = 2'd2;
    localparam logic [1:0] THRESH_RESET   = 2'd2;

    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY
    } state_t;

    typedef struct packed {
        logic       streaming;
        logic [1:0] new_age;
        logic [3:0] victim_way;
    } result_t;

    // Reduces a small value modulo n, valid while v < 8 * n.
    function automatic logic [19:0] mod_small(input logic [19:0] v, input logic [19:0] n);
        logic [19:0] r;
        r = v;
        if (r >= (n << 2)) r = r - (n << 2);
        if (r >= (n << 1)) r = r - (n << 1);
        if (r >= n) r = r - n;
        return r;
    endfunction

endpackage

// ===== rtl/drrip_ram.sv =====
module drrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/drrip_row_update.sv =====
module drrip_row_update #(
    parameter int NUM_SETS       = drrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS       = drrip_pkg::DEF_NUM_WAYS,
    parameter int LEADER_COUNT   = drrip_pkg::DEF_LEADER_COUNT,
    parameter int SIGNATURE_BITS = drrip_pkg::DEF_SIGNATURE_BITS,
    parameter int SELECTOR_BITS  = drrip_pkg::DEF_SELECTOR_BITS,
    localparam int SET_W = $clog2(NUM_SETS),
    localparam int WAY_W = $clog2(NUM_WAYS),
    localparam int ROW_W = NUM_WAYS * (2 + SIGNATURE_BITS) + 130
) (
    input  logic [ROW_W-1:0]          row_i,
    input  logic                      func_i,
    input  logic                      hit_i,
    input  logic [SET_W-1:0]          set_i,
    input  logic [WAY_W-1:0]          way_i,
    input  logic [63:0]               addr_i,
    input  logic [SIGNATURE_BITS-1:0] sig_i,
    input  logic [1:0]                thr_i,
    input  logic [SELECTOR_BITS-1:0]  duel_i,
    input  logic [4:0]                tick_i,
    input  logic [1:0]                sig_cnt_i,
    input  logic [1:0]                old_cnt_i,
    output logic [SIGNATURE_BITS-1:0] old_sig_o,
    output logic [ROW_W-1:0]          row_o,
    output logic [1:0]                old_cnt_o,
    output logic [SELECTOR_BITS-1:0]  duel_o,
    output logic [4:0]                tick_o,
    output drrip_pkg::result_t        res_o
);

    localparam int SIG_BASE  = 2 * NUM_WAYS;
    localparam int ADDR_BASE = NUM_WAYS * (2 + SIGNATURE_BITS);
    localparam int STR_BASE  = ADDR_BASE + 64;
    localparam int RUN_BASE  = STR_BASE + 64;
    localparam int LEAD_BASE = NUM_SETS / 2;
    localparam logic [SELECTOR_BITS-1:0] DUEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
    localparam logic [SELECTOR_BITS-1:0] DUEL_MAX = '1;

    logic [63:0] prev_addr, prev_stride, stride;
    logic [1:0]  run, run_new, top, age;
    logic        prev_zero, same, stream, srrip_lead, brrip_lead, srrip;
    logic [1:0]  sig_cnt_eff;
    logic [WAY_W-1:0] vway;
    logic [ROW_W-1:0] aged_row, upd_row;

    assign old_sig_o   = row_i[SIG_BASE + SIGNATURE_BITS * way_i +: SIGNATURE_BITS];
    assign prev_addr   = row_i[ADDR_BASE +: 64];
    assign prev_stride = row_i[STR_BASE +: 64];
    assign run         = row_i[RUN_BASE +: 2];

    assign prev_zero = (prev_addr == 64'd0);
    assign stride    = prev_zero ? 64'd0 : addr_i - prev_addr;
    assign same      = !prev_zero && (stride == prev_stride) && (stride != 64'd0);
    assign stream    = (run_new >= thr_i);

    always_comb begin
        run_new = run;
        if (same) begin
            if (run != 2'd3) run_new = run + 2'd1;
        end else if (run != 2'd0) begin
            run_new = run - 2'd1;
        end
    end

    assign srrip_lead = (32'(set_i) < 32'(LEADER_COUNT));
    assign brrip_lead = (32'(set_i) >= 32'(LEAD_BASE)) &&
                        (32'(set_i) < 32'(LEAD_BASE + LEADER_COUNT));
    assign srrip      = srrip_lead || (!brrip_lead && (duel_i >= DUEL_MID));

    // Outcome counter of the evicted or hit line's signature.
    always_comb begin
        old_cnt_o = old_cnt_i;
        if (hit_i) begin
            if (old_cnt_i != drrip_pkg::OUTCOME_MAX) old_cnt_o = old_cnt_i + 2'd1;
        end else if (old_cnt_i != 2'd0) begin
            old_cnt_o = old_cnt_i - 2'd1;
        end
    end

    assign sig_cnt_eff = (old_sig_o == sig_i) ? old_cnt_o : sig_cnt_i;

    always_comb begin
        duel_o = duel_i;
        tick_o = tick_i;
        age    = drrip_pkg::AGE_NEAR;
        if (func_i == drrip_pkg::FUNC_UPDATE) begin
            if (hit_i) begin
                if (srrip_lead) begin
                    if (duel_i != DUEL_MAX) duel_o = duel_i + 1'b1;
                end else if (brrip_lead) begin
                    if (duel_i != '0) duel_o = duel_i - 1'b1;
                end
            end else if (stream && sig_cnt_eff < drrip_pkg::OUTCOME_STRONG) begin
                age = drrip_pkg::MAX_AGE;
            end else if (sig_cnt_eff >= drrip_pkg::OUTCOME_STRONG) begin
                age = drrip_pkg::AGE_NEAR;
            end else if (srrip) begin
                age = drrip_pkg::AGE_RESET;
            end else begin
                age    = (tick_i == 5'd0) ? drrip_pkg::AGE_RESET : drrip_pkg::MAX_AGE;
                tick_o = tick_i + 5'd1;
            end
        end
    end

    // Victim search: age every way so the oldest reaches the maximum age.
    always_comb begin
        top      = 2'd0;
        vway     = '0;
        aged_row = row_i;
        for (int i = 0; i < NUM_WAYS; i++) begin
            if (row_i[2*i +: 2] > top) top = row_i[2*i +: 2];
        end
        for (int i = 0; i < NUM_WAYS; i++) begin
            aged_row[2*i +: 2] = row_i[2*i +: 2] + (drrip_pkg::MAX_AGE - top);
        end
        for (int i = NUM_WAYS - 1; i >= 0; i--) begin
            if (aged_row[2*i +: 2] == drrip_pkg::MAX_AGE) vway = WAY_W'(i);
        end
    end

    always_comb begin
        upd_row = row_i;
        upd_row[2*way_i +: 2] = age;
        if (!hit_i) upd_row[SIG_BASE + SIGNATURE_BITS * way_i +: SIGNATURE_BITS] = sig_i;
        upd_row[ADDR_BASE +: 64] = addr_i;
        upd_row[STR_BASE +: 64]  = stride;
        upd_row[RUN_BASE +: 2]   = run_new;
    end

    always_comb begin
        if (func_i == drrip_pkg::FUNC_UPDATE) begin
            row_o            = upd_row;
            res_o.victim_way = 4'd0;
            res_o.new_age    = age;
            res_o.streaming  = stream;
        end else begin
            row_o            = aged_row;
            res_o.victim_way = 4'(vway);
            res_o.new_age    = 2'd0;
            res_o.streaming  = 1'b0;
        end
    end

endmodule

// ===== rtl/drrip_ship_stream_bypass_replacement.sv =====
// Cache replacement policy engine (DRRIP with signature-based insertion and a
// streaming bypass).
//
// Input transfers arrive on the s_ channel. A victim request (tuser bit 0 low)
// ages the addressed set and returns the chosen way. An update (tuser bit 0
// high) trains the stride tracker, the signature outcome counters and the
// set duel counter, and returns the age written for the line and whether the
// set looks like a stream. Every input transfer yields one m_ output transfer.
//
// One item is worked on at a time. The set row and the counter of the new
// signature are read at the input transfer itself, the counter of the line's
// old signature is read in the next cycle, and the modify state then updates
// the row and writes it back once the output register is free. The next input
// is taken after that write-back.
//
// After reset the memories are cleared, one row per cycle, with s_tready low.
// The threshold register can be written through cfg_we between items.
// When the receiver stalls, the result stays in the output register; the next
// item is still accepted, but its write-back waits until the result is taken.
module drrip_ship_stream_bypass_replacement #(
    parameter int NUM_SETS       = drrip_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS       = drrip_pkg::DEF_NUM_WAYS,
    parameter int LEADER_COUNT   = drrip_pkg::DEF_LEADER_COUNT,
    parameter int SIGNATURE_BITS = drrip_pkg::DEF_SIGNATURE_BITS,
    parameter int SELECTOR_BITS  = drrip_pkg::DEF_SELECTOR_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // set_index [10:0], way_index [14:11], phys_addr [78:15], pc_value [142:79]
    input  logic [143:0] s_tdata,
    // func [0], was_hit [1]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // victim_way [3:0], new_age [5:4], streaming [6]
    output logic [7:0]   m_tdata
);

    localparam int SET_W       = $clog2(NUM_SETS);
    localparam int WAY_W       = $clog2(NUM_WAYS);
    localparam int SIG_ENTRIES = 1 << SIGNATURE_BITS;
    localparam int ROW_W       = NUM_WAYS * (2 + SIGNATURE_BITS) + 130;
    localparam int CLR_DEPTH   = (NUM_SETS > SIG_ENTRIES) ? NUM_SETS : SIG_ENTRIES;
    localparam int CLR_W       = $clog2(CLR_DEPTH);
    localparam logic [SELECTOR_BITS-1:0] DUEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));

    drrip_pkg::state_t state_reg, state_next;

    logic [CLR_W-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [1:0]                thr_reg;
    logic [SELECTOR_BITS-1:0]  duel_reg, duel_new;
    logic [4:0]                tick_reg, tick_new;
    logic                      m_valid_reg;
    logic [7:0]                m_data_reg;

    logic                      func_reg, hit_reg;
    logic [SET_W-1:0]          set_reg;
    logic [WAY_W-1:0]          way_reg;
    logic [63:0]               addr_reg;
    logic [SIGNATURE_BITS-1:0] sig_reg;
    logic [1:0]                sig_cnt_reg;

    logic                      accept, out_free, commit;
    logic [SET_W-1:0]          in_set;
    logic [WAY_W-1:0]          in_way;
    logic [SIGNATURE_BITS-1:0] in_sig, old_sig;
    logic [19:0]               set_mod, way_mod;

    logic                      row_we, row_re, cnt_we, cnt_re;
    logic [SET_W-1:0]          row_waddr;
    logic [ROW_W-1:0]          row_wdata, row_rdata, row_upd, row_clear;
    logic [SIGNATURE_BITS-1:0] cnt_waddr, cnt_raddr;
    logic [1:0]                cnt_wdata, cnt_rdata, old_cnt_new;
    drrip_pkg::result_t        res;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign commit   = (state_reg == drrip_pkg::ST_MODIFY) && out_free;

    assign set_mod = drrip_pkg::mod_small(20'(s_tdata[10:0]), 20'(NUM_SETS));
    assign way_mod = drrip_pkg::mod_small(20'(s_tdata[14:11]), 20'(NUM_WAYS));
    assign in_set  = set_mod[SET_W-1:0];
    assign in_way  = way_mod[WAY_W-1:0];
    // Signature: PC bits above the instruction alignment, mixed with the set.
    assign in_sig  = s_tdata[81 +: SIGNATURE_BITS] ^ SIGNATURE_BITS'(set_mod[4:0]);

    always_comb begin
        row_clear = '0;
        for (int i = 0; i < NUM_WAYS; i++) begin
            row_clear[2*i +: 2] = drrip_pkg::AGE_RESET;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            drrip_pkg::ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_W'(CLR_DEPTH - 1)) state_next = drrip_pkg::ST_IDLE;
            end
            drrip_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = drrip_pkg::ST_READ;
            end
            drrip_pkg::ST_READ: begin
                state_next = drrip_pkg::ST_MODIFY;
            end
            drrip_pkg::ST_MODIFY: begin
                if (out_free) state_next = drrip_pkg::ST_IDLE;
            end
            default: begin
                state_next = drrip_pkg::ST_CLEAR;
            end
        endcase
    end

    // Memory control and handshake outputs.
    always_comb begin
        s_tready  = 1'b0;
        row_re    = 1'b0;
        row_we    = 1'b0;
        row_waddr = set_reg;
        row_wdata = row_upd;
        cnt_re    = 1'b0;
        cnt_raddr = in_sig;
        cnt_we    = 1'b0;
        cnt_waddr = old_sig;
        cnt_wdata = old_cnt_new;
        case (state_reg)
            drrip_pkg::ST_CLEAR: begin
                row_we    = (32'(clr_cnt_reg) < 32'(NUM_SETS));
                row_waddr = SET_W'(clr_cnt_reg);
                row_wdata = row_clear;
                cnt_we    = (32'(clr_cnt_reg) < 32'(SIG_ENTRIES));
                cnt_waddr = SIGNATURE_BITS'(clr_cnt_reg);
                cnt_wdata = drrip_pkg::OUTCOME_RESET;
            end
            drrip_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                row_re   = s_tvalid;
                cnt_re   = s_tvalid;
            end
            drrip_pkg::ST_READ: begin
                cnt_re    = 1'b1;
                cnt_raddr = old_sig;
            end
            drrip_pkg::ST_MODIFY: begin
                row_we = out_free;
                cnt_we = out_free && (func_reg == drrip_pkg::FUNC_UPDATE);
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= drrip_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            thr_reg     <= drrip_pkg::THRESH_RESET;
            duel_reg    <= DUEL_MID;
            tick_reg    <= 5'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (cfg_we) thr_reg <= cfg_wdata;
            if (commit) begin
                duel_reg    <= duel_new;
                tick_reg    <= tick_new;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_tuser[0];
            hit_reg  <= s_tuser[1];
            set_reg  <= in_set;
            way_reg  <= in_way;
            addr_reg <= s_tdata[78:15];
            sig_reg  <= in_sig;
        end
        // The counter of the new signature arrives in the cycle after the transfer.
        if (state_reg == drrip_pkg::ST_READ) sig_cnt_reg <= cnt_rdata;
        if (commit) m_data_reg <= {1'b0, res};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (row_waddr),
        .wdata (row_wdata),
        .re    (row_re),
        .raddr (in_set),
        .rdata (row_rdata)
    );

    drrip_ram #(
        .WIDTH (2),
        .DEPTH (SIG_ENTRIES)
    ) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    drrip_row_update #(
        .NUM_SETS       (NUM_SETS),
        .NUM_WAYS       (NUM_WAYS),
        .LEADER_COUNT   (LEADER_COUNT),
        .SIGNATURE_BITS (SIGNATURE_BITS),
        .SELECTOR_BITS  (SELECTOR_BITS)
    ) u_update (
        .row_i     (row_rdata),
        .func_i    (func_reg),
        .hit_i     (hit_reg),
        .set_i     (set_reg),
        .way_i     (way_reg),
        .addr_i    (addr_reg),
        .sig_i     (sig_reg),
        .thr_i     (thr_reg),
        .duel_i    (duel_reg),
        .tick_i    (tick_reg),
        .sig_cnt_i (sig_cnt_reg),
        .old_cnt_i (cnt_rdata),
        .old_sig_o (old_sig),
        .row_o     (row_upd),
        .old_cnt_o (old_cnt_new),
        .duel_o    (duel_new),
        .tick_o    (tick_new),
        .res_o     (res)
    );

endmodule

// ===== rtl/drrip_checker.sv =====
module drrip_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata
);

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Reset drops any pending result.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One item at a time: no input is taken right after a transfer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // A victim result carries no age or streaming flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3:0] != 4'd0 |-> m_tdata[7:4] == 4'd0)
        else $error("victim result with update fields set");

endmodule

bind drrip_ship_stream_bypass_replacement drrip_checker u_checker (.*);
